// ===== rtl/token_bucket_packet_shaper_defines.svh =====
// Assertion macros for the checker file of the token bucket packet shaper.
`ifndef TOKEN_BUCKET_PACKET_SHAPER_DEFINES_SVH
`define TOKEN_BUCKET_PACKET_SHAPER_DEFINES_SVH

// Concurrent assertion that is switched off while reset is applied.
`define TBPS_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Concurrent assertion that also holds while reset is applied.
`define TBPS_ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ===== rtl/tbps_pkg.sv =====
// Types and constants shared by the token bucket packet shaper modules.
`default_nettype none

package tbps_pkg;

  // Request types on the input channel.
  localparam logic REQ_TOKEN  = 1'b0;
  localparam logic REQ_PACKET = 1'b1;

  // Bucket depth after reset.
  localparam logic [7:0] DEPTH_AT_RESET = 8'd10;

  // Event codes reported with each result.
  typedef enum logic [2:0] {
    EV_TOKEN_KEPT   = 3'd0,
    EV_TOKEN_DROP   = 3'd1,
    EV_PACKET_DROP  = 3'd2,
    EV_PACKET_QUEUE = 3'd3,
    EV_PACKET_REL   = 3'd4,
    EV_QUEUE_FULL   = 3'd5
  } event_e;

  // One entry of the waiting queue.
  typedef struct packed {
    logic [15:0] serial;
    logic [7:0]  need;
  } queue_entry_t;

  // One result item.
  typedef struct packed {
    event_e      code;
    logic [15:0] serial;
    logic [7:0]  level;
    logic [7:0]  need;
    logic        last;
  } result_t;

  // Results of one request handed to the result buffer.
  typedef struct packed {
    logic    valid;
    logic    two;
    result_t r0;
    result_t r1;
  } result_push_t;

endpackage

`default_nettype wire

// ===== rtl/tbps_wait_queue.sv =====
// Waiting queue of packets: a memory with the head entry always read out.
`default_nettype none

module tbps_wait_queue #(
  parameter int unsigned QUEUE_DEPTH = 64,
  localparam int unsigned PtrW = $clog2(QUEUE_DEPTH),
  localparam int unsigned CntW = $clog2(QUEUE_DEPTH + 1)
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   push_i,
  input  wire tbps_pkg::queue_entry_t push_entry_i,
  input  wire logic                   pop_i,
  output tbps_pkg::queue_entry_t      head_o,
  output logic [CntW-1:0]             count_o
);

  tbps_pkg::queue_entry_t mem_q [QUEUE_DEPTH];
  tbps_pkg::queue_entry_t rd_data_q;
  tbps_pkg::queue_entry_t byp_data_q;
  logic                   byp_q;
  logic [PtrW-1:0]        head_q, head_d;
  logic [PtrW-1:0]        tail_q, tail_d;
  logic [CntW-1:0]        count_q, count_d;

  function automatic logic [PtrW-1:0] next_ptr(input logic [PtrW-1:0] p);
    next_ptr = (p == PtrW'(QUEUE_DEPTH - 1)) ? '0 : PtrW'(p + PtrW'(1));
  endfunction

  // Pointer and fill count updates. A pop on an empty queue only comes with
  // a push of the same packet, so the count then stays unchanged.
  always_comb begin
    head_d  = pop_i  ? next_ptr(head_q) : head_q;
    tail_d  = push_i ? next_ptr(tail_q) : tail_q;
    count_d = count_q;
    if (push_i && !pop_i) begin
      count_d = CntW'(count_q + CntW'(1));
    end else if (!push_i && pop_i) begin
      count_d = CntW'(count_q - CntW'(1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      tail_q  <= '0;
      count_q <= '0;
      byp_q   <= 1'b0;
    end else begin
      head_q  <= head_d;
      tail_q  <= tail_d;
      count_q <= count_d;
      byp_q   <= push_i && (tail_q == head_d);
    end
  end

  // Memory write, and a registered read of the entry that becomes the head.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[tail_q] <= push_entry_i;
    end
    rd_data_q  <= mem_q[head_d];
    byp_data_q <= push_entry_i;
  end

  // A write to the slot being read is forwarded past the memory.
  assign head_o  = byp_q ? byp_data_q : rd_data_q;
  assign count_o = count_q;

endmodule

`default_nettype wire

// ===== rtl/tbps_result_fifo.sv =====
// Four-entry result buffer taking one or two results per cycle.
`default_nettype none

module tbps_result_fifo (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire tbps_pkg::result_push_t push_i,
  output logic                        room_o,
  output logic                        out_valid_o,
  input  wire logic                   out_stall_i,
  output tbps_pkg::result_t           out_o
);

  localparam int unsigned Depth = 4;
  localparam int unsigned PtrW  = $clog2(Depth);
  localparam int unsigned CntW  = $clog2(Depth + 1);

  tbps_pkg::result_t fifo_q [Depth];
  logic [PtrW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic [1:0]        push_n;
  logic              pop;

  assign pop    = out_valid_o && !out_stall_i;
  assign push_n = !push_i.valid ? 2'd0 : (push_i.two ? 2'd2 : 2'd1);

  // Pointer and count updates.
  always_comb begin
    wr_ptr_d = PtrW'(wr_ptr_q + PtrW'(push_n));
    rd_ptr_d = pop ? PtrW'(rd_ptr_q + PtrW'(1)) : rd_ptr_q;
    cnt_d    = CntW'(cnt_q + CntW'(push_n) - CntW'(pop));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Result storage.
  always_ff @(posedge clk_i) begin
    if (push_i.valid) begin
      fifo_q[wr_ptr_q] <= push_i.r0;
      if (push_i.two) begin
        fifo_q[PtrW'(wr_ptr_q + PtrW'(1))] <= push_i.r1;
      end
    end
  end

  // Room for two results is needed before a request is processed.
  assign room_o      = (cnt_q <= CntW'(Depth - 2));
  assign out_valid_o = (cnt_q != '0);
  assign out_o       = fifo_q[rd_ptr_q];

endmodule

`default_nettype wire

// ===== rtl/token_bucket_packet_shaper.sv =====
// Token bucket packet shaper top level with its waiting queue and result buffer.
// A request is registered, processed once the result buffer has room, and its
// results are written to the result buffer, which offers them on the output.
// Throughput: one request per cycle while the result buffer has room; a request
// with two results gives them out one after the other from the result buffer.
// Reset clears the bucket, counters and queue pointers; depth returns to 10.
`default_nettype none

module token_bucket_packet_shaper #(
  parameter int unsigned QUEUE_DEPTH = 64
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // Configuration write channel.
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [7:0]  cfg_bucket_depth_i,
  // Request channel.
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic        req_type_i,
  input  wire logic [7:0]  tokens_needed_i,
  // Result channel.
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [2:0]       event_code_o,
  output logic [15:0]      serial_number_o,
  output logic [7:0]       bucket_level_o,
  output logic [7:0]       packet_need_o,
  output logic             last_result_o
);

  localparam int unsigned CntW = $clog2(QUEUE_DEPTH + 1);

  logic [7:0]             depth_q;
  logic [7:0]             level_q, level_d;
  logic [15:0]            tc_q, tc_d;
  logic [15:0]            pc_q, pc_d;
  logic                   iv_q;
  logic                   req_q;
  logic [7:0]             need_q;
  logic                   fire;
  logic                   room;
  logic [7:0]             lvl_inc;
  logic [15:0]            tc_inc, pc_inc;
  logic                   q_push, q_pop;
  tbps_pkg::queue_entry_t q_entry;
  tbps_pkg::queue_entry_t q_head;
  logic [CntW-1:0]        q_count;
  tbps_pkg::result_push_t res_push;
  tbps_pkg::result_t      res_out;

  // Configuration is always taken.
  assign cfg_ready_o = 1'b1;

  // The request register is processed once the result buffer has room.
  assign fire       = iv_q && room;
  assign in_stall_o = iv_q && !room;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      depth_q <= tbps_pkg::DEPTH_AT_RESET;
      level_q <= '0;
      tc_q    <= '0;
      pc_q    <= '0;
      iv_q    <= 1'b0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        depth_q <= cfg_bucket_depth_i;
      end
      level_q <= level_d;
      tc_q    <= tc_d;
      pc_q    <= pc_d;
      if (in_valid_i && !in_stall_o) begin
        iv_q <= 1'b1;
      end else if (fire) begin
        iv_q <= 1'b0;
      end
    end
  end

  // Request payload register.
  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      req_q  <= req_type_i;
      need_q <= tokens_needed_i;
    end
  end

  assign lvl_inc = 8'(level_q + 8'd1);
  assign tc_inc  = 16'(tc_q + 16'd1);
  assign pc_inc  = 16'(pc_q + 16'd1);

  // Event processing: bucket and queue checks, level and counter updates and queue operations.
  always_comb begin
    level_d        = level_q;
    tc_d           = tc_q;
    pc_d           = pc_q;
    q_push         = 1'b0;
    q_pop          = 1'b0;
    q_entry.serial = pc_inc;
    q_entry.need   = need_q;
    res_push       = '0;
    if (fire) begin
      res_push.valid = 1'b1;
      if (req_q == tbps_pkg::REQ_TOKEN) begin
        tc_d = tc_inc;
        res_push.r0.serial = tc_inc;
        res_push.r0.need   = '0;
        res_push.r0.last   = 1'b1;
        if (level_q >= depth_q) begin
          res_push.r0.code  = tbps_pkg::EV_TOKEN_DROP;
          res_push.r0.level = level_q;
        end else begin
          res_push.r0.code = tbps_pkg::EV_TOKEN_KEPT;
          level_d          = lvl_inc;
          // The head packet leaves once the bucket covers its need.
          if ((q_count != '0) && (lvl_inc >= q_head.need)) begin
            q_pop               = 1'b1;
            level_d             = 8'(lvl_inc - q_head.need);
            res_push.two        = 1'b1;
            res_push.r0.last    = 1'b0;
            res_push.r1.code    = tbps_pkg::EV_PACKET_REL;
            res_push.r1.serial  = q_head.serial;
            res_push.r1.need    = q_head.need;
            res_push.r1.last    = 1'b1;
          end
          res_push.r0.level = level_d;
          res_push.r1.level = level_d;
        end
      end else begin
        pc_d = pc_inc;
        res_push.r0.serial = pc_inc;
        res_push.r0.need   = need_q;
        res_push.r0.last   = 1'b1;
        res_push.r0.level  = level_q;
        if (need_q > depth_q) begin
          res_push.r0.code = tbps_pkg::EV_PACKET_DROP;
        end else if (q_count == CntW'(QUEUE_DEPTH)) begin
          res_push.r0.code = tbps_pkg::EV_QUEUE_FULL;
        end else begin
          res_push.r0.code = tbps_pkg::EV_PACKET_QUEUE;
          q_push           = 1'b1;
          // A packet arriving at an empty queue is checked straight away.
          if ((q_count == '0) && (level_q >= need_q)) begin
            q_pop              = 1'b1;
            level_d            = 8'(level_q - need_q);
            res_push.two       = 1'b1;
            res_push.r0.last   = 1'b0;
            res_push.r1.code   = tbps_pkg::EV_PACKET_REL;
            res_push.r1.serial = pc_inc;
            res_push.r1.need   = need_q;
            res_push.r1.last   = 1'b1;
          end
          res_push.r0.level = level_d;
          res_push.r1.level = level_d;
        end
      end
    end
  end

  tbps_wait_queue #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_wait_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (q_push),
    .push_entry_i (q_entry),
    .pop_i        (q_pop),
    .head_o       (q_head),
    .count_o      (q_count)
  );

  tbps_result_fifo u_result_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (res_push),
    .room_o      (room),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_o       (res_out)
  );

  // Result fields.
  assign event_code_o    = res_out.code;
  assign serial_number_o = res_out.serial;
  assign bucket_level_o  = res_out.level;
  assign packet_need_o   = res_out.need;
  assign last_result_o   = res_out.last;

endmodule

`default_nettype wire

// ===== rtl/tbps_checker.sv =====
// Port checker for the token bucket packet shaper and its bind statement.
`default_nettype none
`include "token_bucket_packet_shaper_defines.svh"

module tbps_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        cfg_valid_i,
  input wire logic        cfg_ready_o,
  input wire logic [7:0]  cfg_bucket_depth_i,
  input wire logic        in_valid_i,
  input wire logic        in_stall_o,
  input wire logic        req_type_i,
  input wire logic [7:0]  tokens_needed_i,
  input wire logic        out_valid_o,
  input wire logic        out_stall_i,
  input wire logic [2:0]  event_code_o,
  input wire logic [15:0] serial_number_o,
  input wire logic [7:0]  bucket_level_o,
  input wire logic [7:0]  packet_need_o,
  input wire logic        last_result_o
);

  logic        out_held;
  logic [35:0] out_payload;
  logic        token_ev;
  logic        final_ev;

  // Shorthands for the result channel.
  assign out_held    = out_valid_o && out_stall_i;
  assign out_payload = {event_code_o, serial_number_o, bucket_level_o, packet_need_o,
                        last_result_o};
  assign token_ev    = out_valid_o && (event_code_o == tbps_pkg::EV_TOKEN_KEPT ||
                                       event_code_o == tbps_pkg::EV_TOKEN_DROP);
  assign final_ev    = out_valid_o && (event_code_o == tbps_pkg::EV_TOKEN_DROP ||
                                       event_code_o == tbps_pkg::EV_PACKET_DROP ||
                                       event_code_o == tbps_pkg::EV_QUEUE_FULL ||
                                       event_code_o == tbps_pkg::EV_PACKET_REL);

  // A stalled result stays offered.
  `TBPS_ASSERT_RST(a_out_hold, out_held |=> out_valid_o, "result withdrawn while stalled")

  // A stalled result keeps its payload.
  `TBPS_ASSERT_RST(a_out_stable, out_held |=> $stable(out_payload), "stalled result changed")

  // Token events carry no packet need.
  `TBPS_ASSERT_RST(a_token_need, token_ev |-> packet_need_o == 8'd0, "token event with a need")

  // Drops, refusals and releases always close their request.
  `TBPS_ASSERT_RST(a_final_codes, final_ev |-> last_result_o, "final event not marked last")

  // Once reset has been applied at an edge, no result is offered at the next one.
  `TBPS_ASSERT_CLK(a_reset_idle, !rst_ni |=> !out_valid_o, "result offered during reset")

endmodule

bind token_bucket_packet_shaper tbps_checker u_tbps_checker (.*);

`default_nettype wire
